@@ hdl/ccb_pkg.sv @@
`default_nettype none
package ccb_pkg;

  // input word: one pixel load or one box read
  typedef struct packed {
    logic        command;
    logic [7:0]  gray;
    logic [11:0] region_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        labeling_done;
    logic [12:0] region_count;
    logic        region_found;
    logic [6:0]  min_row;
    logic [6:0]  max_row;
    logic [8:0]  min_col;
    logic [8:0]  max_col;
    logic        table_overflow;
  } out_word_t;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_GRAY_THRESHOLD = 2'd2;

  // configuration widths and reset values
  localparam int CFG_DATA_W = 10;
  localparam logic [9:0] WIDTH_RST     = 10'd320;
  localparam logic [7:0] HEIGHT_RST    = 8'd120;
  localparam logic [7:0] THRESHOLD_RST = 8'd128;

  // pixel store bits
  localparam int PIX_FG  = 1;
  localparam int PIX_VIS = 0;

  // output field widths
  localparam int OUT_ROW_W = 7;
  localparam int OUT_COL_W = 9;
  localparam int OUT_CNT_W = 13;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_Q_RD,
    ST_Q_DATA,
    ST_N_ADDR,
    ST_N_CHK
  } state_t;

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_UP,
    DIR_RIGHT,
    DIR_LEFT
  } dir_t;

endpackage
`default_nettype wire

@@ hdl/ccb_ram.sv @@
`default_nettype none
module ccb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/ccb_nbr.sv @@
`default_nettype none
module ccb_nbr #(
  parameter int AW = 16,
  parameter int RW = 7,
  parameter int CW = 9,
  parameter int WW = 10,
  parameter int HW = 8
) (
  input  wire logic [AW-1:0]     p,
  input  wire logic [RW-1:0]     row,
  input  wire logic [CW-1:0]     col,
  input  wire ccb_pkg::dir_t     dir,
  input  wire logic [WW-1:0]     w,
  input  wire logic [HW-1:0]     h,
  output logic                   ok,
  output logic [AW-1:0]          np,
  output logic [RW-1:0]          nrow,
  output logic [CW-1:0]          ncol
);
  // shared neighbor step: bounds check and address add or subtract for one direction
  always_comb begin
    ok   = 1'b0;
    np   = p;
    nrow = row;
    ncol = col;
    unique case (dir)
      ccb_pkg::DIR_DOWN: begin
        ok   = (32'(row) + 32'd1) < 32'(h);
        np   = AW'(32'(p) + 32'(w));
        nrow = RW'(32'(row) + 32'd1);
      end
      ccb_pkg::DIR_UP: begin
        ok   = (row != '0);
        np   = AW'(32'(p) - 32'(w));
        nrow = RW'(32'(row) - 32'd1);
      end
      ccb_pkg::DIR_RIGHT: begin
        ok   = (32'(col) + 32'd1) < 32'(w);
        np   = AW'(32'(p) + 32'd1);
        ncol = CW'(32'(col) + 32'd1);
      end
      ccb_pkg::DIR_LEFT: begin
        ok   = (col != '0);
        np   = AW'(32'(p) - 32'd1);
        ncol = CW'(32'(col) - 32'd1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/threshold_connected_component_boxes_core.sv @@
// channel  | ports                          | moves
// in       | in_valid, in_ready, in_data    | load pixel or read region box word
// out      | out_valid, out_ready, out_data | one result word per input word
// cfg      | cfg_we, cfg_index, cfg_wdata   | register write, no wait
//
// a non-final pixel load answers from ST_IDLE, a box read from ST_RD_OUT; the frame-ending
// load runs the flood fill: SCAN_RD, SCAN_CHK per scanned pixel, SCAN_RD to finish, Q_RD,
// Q_DATA per queued pixel, Q_RD per finished region, N_ADDR and, if in bounds, N_CHK per
// neighbor (registered store read); visited bits clear as each pixel loads, no clearing pass
// reset is synchronous active low; out_ready low holds the result register
`default_nettype none
module threshold_connected_component_boxes_core #(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 128,
  parameter int MAX_REGIONS = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ccb_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ccb_pkg::out_word_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [ccb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(PIX);
  localparam int PW   = $clog2(PIX + 1);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int TW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam int QW   = AW + RW + CW;
  localparam int BW   = 2 * RW + 2 * CW;

  // registers
  logic [9:0]          cfg_width_r;
  logic [7:0]          cfg_height_r;
  logic [7:0]          cfg_thr_r;
  ccb_pkg::state_t     state_r, state_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       area_r, area_nxt;
  logic [CNTW-1:0]     count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                done_r, done_nxt;
  logic [PW-1:0]       s_r, s_nxt;
  logic [RW-1:0]       sr_r, sr_nxt;
  logic [CW-1:0]       sc_r, sc_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [PW-1:0]       tail_r, tail_nxt;
  logic [AW-1:0]       cur_p_r, cur_p_nxt;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;
  ccb_pkg::dir_t       dir_r, dir_nxt;
  logic [RW-1:0]       rmin_r, rmin_nxt, rmax_r, rmax_nxt;
  logic [CW-1:0]       cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  ccb_pkg::out_word_t  out_data_r, out_data_nxt;

  // memory ports
  logic                pix_we;
  logic [AW-1:0]       pix_waddr, pix_raddr;
  logic [1:0]          pix_wdata, pix_rdata;
  logic                q_we;
  logic [AW-1:0]       q_waddr, q_raddr;
  logic [QW-1:0]       q_wdata, q_rdata;
  logic                t_we;
  logic [TW-1:0]       t_waddr, t_raddr;
  logic [BW-1:0]       t_wdata, t_rdata;

  // misc combinational
  logic                in_acc;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  logic [PW-1:0]       area_now;
  logic [PW-1:0]       pos_base, pos_inc;
  logic                trigger;
  logic                read_hit;
  logic                scan_hit;
  logic                push;
  logic                nb_ok;
  logic [AW-1:0]       nb_p;
  logic [RW-1:0]       nb_row;
  logic [CW-1:0]       nb_col;
  logic [AW-1:0]       q_p;
  logic [RW-1:0]       q_row;
  logic [CW-1:0]       q_col;
  logic [RW-1:0]       t_rmin, t_rmax;
  logic [CW-1:0]       t_cmin, t_cmax;
  logic                fg;

  assign in_ready  = (state_r == ccb_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective dimensions and frame size
  assign w_eff = (cfg_width_r == '0) ? WW'(1) :
                 (32'(cfg_width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_width_r);
  assign h_eff = (cfg_height_r == '0) ? HW'(1) :
                 (32'(cfg_height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_height_r);
  assign area_now = PW'(32'(w_eff) * 32'(h_eff));

  // load position, a load after done starts a new frame
  assign pos_base = done_r ? '0 : pos_r;
  assign pos_inc  = pos_base + PW'(1);
  assign trigger  = (pos_inc >= area_now);
  assign fg       = (in_data.gray < cfg_thr_r);

  assign read_hit = done_r && (32'(in_data.region_index) < 32'(count_r)) &&
                    (32'(in_data.region_index) < MAX_REGIONS);

  assign scan_hit = pix_rdata[ccb_pkg::PIX_FG] && !pix_rdata[ccb_pkg::PIX_VIS];
  assign push     = scan_hit && (32'(tail_r) < PIX);

  assign {q_p, q_row, q_col}             = q_rdata;
  assign {t_rmin, t_rmax, t_cmin, t_cmax} = t_rdata;

  // neighbor address and bounds unit, shared by all four directions
  ccb_nbr #(.AW(AW), .RW(RW), .CW(CW), .WW(WW), .HW(HW)) u_nbr (
    .p    (cur_p_r),
    .row  (cur_row_r),
    .col  (cur_col_r),
    .dir  (dir_r),
    .w    (w_eff),
    .h    (h_eff),
    .ok   (nb_ok),
    .np   (nb_p),
    .nrow (nb_row),
    .ncol (nb_col)
  );

  // pixel store: foreground and visited bit per raster position
  ccb_ram #(.WIDTH(2), .DEPTH(PIX)) u_pix (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // flood queue of position, row and column
  ccb_ram #(.WIDTH(QW), .DEPTH(PIX)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // region box table
  ccb_ram #(.WIDTH(BW), .DEPTH(MAX_REGIONS)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccb_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == ccb_pkg::CMD_READ) begin
            state_nxt = ccb_pkg::ST_RD_OUT;
          end else if (trigger) begin
            state_nxt = ccb_pkg::ST_SCAN_RD;
          end
        end
      end
      ccb_pkg::ST_RD_OUT:   state_nxt = ccb_pkg::ST_IDLE;
      ccb_pkg::ST_SCAN_RD: begin
        state_nxt = (s_r == area_r) ? ccb_pkg::ST_IDLE : ccb_pkg::ST_SCAN_CHK;
      end
      ccb_pkg::ST_SCAN_CHK: begin
        state_nxt = scan_hit ? ccb_pkg::ST_Q_RD : ccb_pkg::ST_SCAN_RD;
      end
      ccb_pkg::ST_Q_RD: begin
        state_nxt = (head_r == tail_r) ? ccb_pkg::ST_SCAN_RD : ccb_pkg::ST_Q_DATA;
      end
      ccb_pkg::ST_Q_DATA:   state_nxt = ccb_pkg::ST_N_ADDR;
      ccb_pkg::ST_N_ADDR: begin
        if (nb_ok) begin
          state_nxt = ccb_pkg::ST_N_CHK;
        end else if (dir_r == ccb_pkg::DIR_LEFT) begin
          state_nxt = ccb_pkg::ST_Q_RD;
        end
      end
      ccb_pkg::ST_N_CHK: begin
        state_nxt = (dir_r == ccb_pkg::DIR_LEFT) ? ccb_pkg::ST_Q_RD : ccb_pkg::ST_N_ADDR;
      end
      default:              state_nxt = ccb_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pos_nxt      = pos_r;
    area_nxt     = area_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    done_nxt     = done_r;
    s_nxt        = s_r;
    sr_nxt       = sr_r;
    sc_nxt       = sc_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cur_p_nxt    = cur_p_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    dir_nxt      = dir_r;
    rmin_nxt     = rmin_r;
    rmax_nxt     = rmax_r;
    cmin_nxt     = cmin_r;
    cmax_nxt     = cmax_r;
    found_nxt    = found_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pix_we    = 1'b0;
    pix_waddr = AW'(pos_base);
    pix_wdata = '0;
    pix_raddr = AW'(s_r);
    q_we      = 1'b0;
    q_waddr   = AW'(tail_r);
    q_wdata   = {nb_p, nb_row, nb_col};
    q_raddr   = AW'(head_r);
    t_we      = 1'b0;
    t_waddr   = TW'(count_r);
    t_wdata   = {rmin_r, rmax_r, cmin_r, cmax_r};
    t_raddr   = TW'(in_data.region_index);

    unique case (state_r)
      ccb_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == ccb_pkg::CMD_READ) begin
            found_nxt = read_hit;
          end else begin
            // store pixel, visited bit cleared for this frame
            pix_we    = 1'b1;
            pix_wdata[ccb_pkg::PIX_FG]  = fg;
            pix_wdata[ccb_pkg::PIX_VIS] = 1'b0;
            done_nxt = 1'b0;
            if (done_r) begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            if (trigger) begin
              pos_nxt   = '0;
              area_nxt  = area_now;
              count_nxt = '0;
              ovf_nxt   = 1'b0;
              s_nxt     = '0;
              sr_nxt    = '0;
              sc_nxt    = '0;
            end else begin
              pos_nxt       = pos_inc;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.region_count   = done_r ? '0 : ccb_pkg::OUT_CNT_W'(count_r);
              out_data_nxt.table_overflow = done_r ? 1'b0 : ovf_r;
            end
          end
        end
      end
      ccb_pkg::ST_RD_OUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.labeling_done  = done_r;
        out_data_nxt.region_count   = ccb_pkg::OUT_CNT_W'(count_r);
        out_data_nxt.table_overflow = ovf_r;
        if (found_r) begin
          out_data_nxt.region_found = 1'b1;
          out_data_nxt.min_row = ccb_pkg::OUT_ROW_W'(t_rmin);
          out_data_nxt.max_row = ccb_pkg::OUT_ROW_W'(t_rmax);
          out_data_nxt.min_col = ccb_pkg::OUT_COL_W'(t_cmin);
          out_data_nxt.max_col = ccb_pkg::OUT_COL_W'(t_cmax);
        end
      end
      ccb_pkg::ST_SCAN_RD: begin
        // frame finished: report the labeling result
        if (s_r == area_r) begin
          done_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.labeling_done  = 1'b1;
          out_data_nxt.region_count   = ccb_pkg::OUT_CNT_W'(count_r);
          out_data_nxt.table_overflow = ovf_r;
        end
      end
      ccb_pkg::ST_SCAN_CHK: begin
        // seed a new region
        if (scan_hit) begin
          pix_we    = 1'b1;
          pix_waddr = AW'(s_r);
          pix_wdata = 2'b11;
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {AW'(s_r), sr_r, sc_r};
          head_nxt  = '0;
          tail_nxt  = PW'(1);
          rmin_nxt  = sr_r;
          rmax_nxt  = sr_r;
          cmin_nxt  = sc_r;
          cmax_nxt  = sc_r;
        end
        // advance raster scan
        s_nxt = s_r + PW'(1);
        if ((32'(sc_r) + 32'd1) == 32'(w_eff)) begin
          sc_nxt = '0;
          sr_nxt = sr_r + RW'(1);
        end else begin
          sc_nxt = sc_r + CW'(1);
        end
      end
      ccb_pkg::ST_Q_RD: begin
        if (head_r == tail_r) begin
          // region complete
          if (32'(count_r) < MAX_REGIONS) begin
            t_we      = 1'b1;
            count_nxt = count_r + CNTW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          head_nxt = head_r + PW'(1);
        end
      end
      ccb_pkg::ST_Q_DATA: begin
        // take dequeued pixel, grow box
        cur_p_nxt   = q_p;
        cur_row_nxt = q_row;
        cur_col_nxt = q_col;
        dir_nxt     = ccb_pkg::DIR_DOWN;
        if (q_row < rmin_r) rmin_nxt = q_row;
        if (q_row > rmax_r) rmax_nxt = q_row;
        if (q_col < cmin_r) cmin_nxt = q_col;
        if (q_col > cmax_r) cmax_nxt = q_col;
      end
      ccb_pkg::ST_N_ADDR: begin
        pix_raddr = nb_p;
        if (!nb_ok && dir_r != ccb_pkg::DIR_LEFT) begin
          dir_nxt = ccb_pkg::dir_t'(2'(dir_r) + 2'd1);
        end
      end
      ccb_pkg::ST_N_CHK: begin
        if (push) begin
          pix_we    = 1'b1;
          pix_waddr = nb_p;
          pix_wdata = 2'b11;
          q_we      = 1'b1;
          tail_nxt  = tail_r + PW'(1);
        end
        if (dir_r != ccb_pkg::DIR_LEFT) begin
          dir_nxt = ccb_pkg::dir_t'(2'(dir_r) + 2'd1);
        end
      end
      default: begin
        done_nxt = done_r;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= ccb_pkg::WIDTH_RST;
      cfg_height_r <= ccb_pkg::HEIGHT_RST;
      cfg_thr_r    <= ccb_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccb_pkg::REG_IMAGE_WIDTH:    cfg_width_r  <= cfg_wdata;
        ccb_pkg::REG_IMAGE_HEIGHT:   cfg_height_r <= cfg_wdata[7:0];
        ccb_pkg::REG_GRAY_THRESHOLD: cfg_thr_r    <= cfg_wdata[7:0];
        default:                     cfg_thr_r    <= cfg_thr_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccb_pkg::ST_IDLE;
      pos_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencer payload registers
  always_ff @(posedge clk) begin
    area_r     <= area_nxt;
    s_r        <= s_nxt;
    sr_r       <= sr_nxt;
    sc_r       <= sc_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    cur_p_r    <= cur_p_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    dir_r      <= dir_nxt;
    rmin_r     <= rmin_nxt;
    rmax_r     <= rmax_nxt;
    cmin_r     <= cmin_nxt;
    cmax_r     <= cmax_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/ccb_chk.sv @@
`default_nettype none
module ccb_chk #(
  parameter int MAX_REGIONS = 4096
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ccb_pkg::out_word_t out_data
);
  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a found region only exists after labeling
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.region_found |->
      out_data.labeling_done && out_data.region_count != '0)
    else $error("region found without labeling");

  // a miss carries an empty box
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.region_found |->
      out_data.min_row == '0 && out_data.max_row == '0 &&
      out_data.min_col == '0 && out_data.max_col == '0)
    else $error("box fields set on a miss");

  // overflow only with a full table
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_overflow |->
      out_data.region_count == ccb_pkg::OUT_CNT_W'(MAX_REGIONS))
    else $error("overflow with table not full");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind threshold_connected_component_boxes_core ccb_chk #(.MAX_REGIONS(MAX_REGIONS)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
